>>> src/idm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the image difference metric unit.
// No dependencies.
package idm_pkg;

  localparam int LANES       = 4;
  localparam int SAMPLE_W    = 8;
  localparam int SQ_W        = 2 * SAMPLE_W;
  localparam int SQSUM_W     = SQ_W + $clog2(LANES);
  localparam int LIMIT_W     = 10;
  localparam int LIMSQ_W     = 2 * LIMIT_W;
  localparam int FRAC_BITS   = 8;
  localparam int RAD_W       = SQSUM_W + 2 * FRAC_BITS;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int STEP_W      = $clog2(ROOT_W + 1);
  localparam int COUNT_W     = 25;
  localparam int ACC_W       = 41;
  localparam int CH_W        = 3;
  localparam int MODE_W      = 2;
  localparam int IDX_W       = 2;
  localparam int OUT_DATA_W  = 104;

  localparam logic [COUNT_W-1:0] MAX_PIXELS = COUNT_W'(1) << (COUNT_W - 1);
  localparam logic [ACC_W-1:0]   ACC_MAX    = '1;
  localparam logic [SAMPLE_W-1:0] DIFF_MARK = '1;

  localparam logic [MODE_W-1:0] MODE_PIXELS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_L2     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TOTAL  = 2'd2;

  localparam logic [IDX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [IDX_W-1:0] REG_CHANNELS = 2'd1;
  localparam logic [IDX_W-1:0] REG_LIMIT    = 2'd2;

  typedef struct packed {
    logic            ne;
    logic [SQ_W-1:0] sq;
  } lane_res_t;

  typedef struct packed {
    logic               differs;
    logic               under_limit;
    logic [SQSUM_W-1:0] sq_sum;
  } merge_res_t;

endpackage

>>> src/idm_lane.sv
`timescale 1ns / 1ps
// One channel lane: absolute difference, square and mismatch flag, registered.
// Depends on idm_pkg.
module idm_lane import idm_pkg::*; (
  input  logic                clk,
  input  logic                load,
  input  logic                en,
  input  logic [SAMPLE_W-1:0] a,
  input  logic [SAMPLE_W-1:0] b,
  output lane_res_t           res
);

  logic [SAMPLE_W-1:0] diff;
  logic [SQ_W-1:0]     sq;

  always_comb begin
    diff = (a >= b) ? (a - b) : (b - a);
    sq   = SQ_W'(diff) * SQ_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.ne <= en && (a != b);
      res.sq <= en ? sq : '0;
    end
  end

endmodule

>>> src/idm_merge.sv
`timescale 1ns / 1ps
// Merge stage: sums lane squares, ORs mismatch flags, checks the outlier limit.
// Depends on idm_pkg.
module idm_merge import idm_pkg::*; (
  input  logic               clk,
  input  lane_res_t          lanes [LANES],
  input  logic [LIMSQ_W-1:0] lim_sq,
  output merge_res_t         res
);

  logic [SQSUM_W-1:0] sum;
  logic               any_ne;

  always_comb begin
    sum    = '0;
    any_ne = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      sum    = sum + SQSUM_W'(lanes[i].sq);
      any_ne = any_ne | lanes[i].ne;
    end
  end

  always_ff @(posedge clk) begin
    res.sq_sum      <= sum;
    res.differs     <= any_ne;
    res.under_limit <= LIMSQ_W'(sum) < lim_sq;
  end

endmodule

>>> src/idm_sqrt.sv
`timescale 1ns / 1ps
// Bit-serial integer square root of (sum of squares << 2*FRAC_BITS),
// one root bit per cycle. Depends on idm_pkg.
module idm_sqrt import idm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SQSUM_W-1:0] radicand,
  output logic               done,
  output logic [ROOT_W-1:0]  root
);

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W:0]   rem;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] cand;
  logic [ROOT_W+2:0] sub;
  logic              ge;

  always_comb begin
    trial = {rem, rad[RAD_W-1 -: 2]};
    cand  = {1'b0, root, 2'b01};
    sub   = trial - cand;
    ge    = trial >= cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(ROOT_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {radicand, {(2 * FRAC_BITS){1'b0}}};
      root <= '0;
      rem  <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      root <= {root[ROOT_W-2:0], ge};
      rem  <= ge ? sub[ROOT_W:0] : trial[ROOT_W:0];
    end
  end

endmodule

>>> src/image_difference_metric_unit.sv
`timescale 1ns / 1ps
// Top level of the image difference metric unit: lanes, merge, root, totals.
// Depends on idm_pkg, idm_lane, idm_merge, idm_sqrt.
//
//  channel  | dir | handshake               | word
//  ---------+-----+-------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | 8 samples, tlast = end_of_image
//  m_axis   | out | m_axis_tvalid/tready    | pixel result and totals, tlast
//  cfg      | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// One pixel at a time; a pixel whose distance is summed (L2 mode, below the
// outlier limit) also waits for the 17-step serial square root.
// rst is synchronous and clears control state and all totals.
// A stalled result sits in the output register; the next pixel is taken
// meanwhile and waits in the last stage until the register frees.
module image_difference_metric_unit import idm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // a_ch0, a_ch1, a_ch2, a_ch3, b_ch0, b_ch1, b_ch2, b_ch3
  input  logic [2*LANES*SAMPLE_W-1:0] s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // diff_pixel, differing_pixels, pixel_total, l2_sum, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [LIMIT_W-1:0]    cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_ROOT  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [MODE_W-1:0]  mode;
  logic [CH_W-1:0]    channels_in_use;
  logic [LIMIT_W-1:0] outlier_limit;
  logic [LIMSQ_W-1:0] lim_sq;
  logic               eoi;
  logic               add_root;
  logic [COUNT_W-1:0] differing_count;
  logic [COUNT_W-1:0] pixel_count;
  logic [ACC_W-1:0]   acc;
  logic [COUNT_W-1:0] differing_next;
  logic [COUNT_W-1:0] pixel_next;
  logic [ACC_W-1:0]   acc_next;
  logic [ACC_W:0]     acc_sum;
  logic [SAMPLE_W-1:0] diff_pixel;
  logic               in_acc;
  logic               out_wr;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [ROOT_W-1:0]  root;
  lane_res_t          lane_res [LANES];
  merge_res_t         mres;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_wr        = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign sqrt_start    = (state == ST_CHECK) && (mode == MODE_L2) && mres.under_limit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_L2;
      channels_in_use <= CH_W'(3);
      outlier_limit   <= LIMIT_W'(1000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:     mode            <= cfg_data[MODE_W-1:0];
        REG_CHANNELS: channels_in_use <= cfg_data[CH_W-1:0];
        REG_LIMIT:    outlier_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim_sq <= LIMSQ_W'(outlier_limit) * LIMSQ_W'(outlier_limit);
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    idm_lane u_lane (
      .clk  (clk),
      .load (in_acc),
      .en   (channels_in_use > CH_W'(i)),
      .a    (s_axis_tdata[i*SAMPLE_W +: SAMPLE_W]),
      .b    (s_axis_tdata[(LANES+i)*SAMPLE_W +: SAMPLE_W]),
      .res  (lane_res[i])
    );
  end

  idm_merge u_merge (
    .clk    (clk),
    .lanes  (lane_res),
    .lim_sq (lim_sq),
    .res    (mres)
  );

  idm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (mres.sq_sum),
    .done     (sqrt_done),
    .root     (root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc) state_next = ST_SUM;
      ST_SUM:   state_next = ST_CHECK;
      ST_CHECK: state_next = sqrt_start ? ST_ROOT : ST_DONE;
      ST_ROOT:  if (sqrt_done) state_next = ST_DONE;
      ST_DONE:  if (out_wr) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      add_root <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CHECK) begin
        add_root <= sqrt_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      eoi <= s_axis_tlast;
    end
  end

  // result and running totals
  always_comb begin
    differing_next = differing_count;
    acc_next       = acc;
    diff_pixel     = '0;
    acc_sum        = {1'b0, acc} + (ACC_W + 1)'(root);
    case (mode)
      MODE_PIXELS: begin
        if (mres.differs) begin
          diff_pixel = DIFF_MARK;
          if (differing_count < MAX_PIXELS) begin
            differing_next = differing_count + 1'b1;
          end
        end
      end
      MODE_L2: begin
        diff_pixel = (mres.sq_sum > SQSUM_W'(DIFF_MARK)) ? DIFF_MARK
                                                         : mres.sq_sum[SAMPLE_W-1:0];
        if (add_root) begin
          acc_next = (acc_sum >= {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];
        end
      end
      default: ;
    endcase
    pixel_next = (pixel_count < MAX_PIXELS) ? pixel_count + 1'b1 : pixel_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      differing_count <= '0;
      pixel_count     <= '0;
      acc             <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (out_wr) begin
        m_axis_tvalid <= 1'b1;
        if (eoi) begin
          differing_count <= '0;
          pixel_count     <= '0;
          acc             <= '0;
        end else begin
          differing_count <= differing_next;
          pixel_count     <= pixel_next;
          acc             <= acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) begin
      m_axis_tdata <= OUT_DATA_W'({acc_next, pixel_next, differing_next, diff_pixel});
      m_axis_tlast <= eoi;
    end
  end

  // a new pixel is taken only from idle and goes straight to the merge stage
  a_accept_to_sum: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_SUM)
    else $error("pixel accepted outside idle");

  // the root unit signals done only in the root state
  a_root_done: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == ST_ROOT)
    else $error("root finished outside root state");

  // closing pixel clears the totals
  a_eoi_clear: assert property (@(posedge clk) disable iff (rst)
    (out_wr && eoi) |=> (pixel_count == '0 && differing_count == '0 && acc == '0))
    else $error("totals not cleared after end of image");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    (pixel_count <= MAX_PIXELS) && (differing_count <= pixel_count))
    else $error("pixel counters out of range");

endmodule
